// File: rtl/core/fsp8_pkg.sv
// ----------------------------------------------------------------------------
// fsp8_pkg: shared types and constants
// Request and response types, instruction opcodes, request codes, counter
// indexes and the relative jump helper of the five-stage 8-bit processor.
// ----------------------------------------------------------------------------
package fsp8_pkg;

	localparam int IMEM_DEPTH = 128;
	localparam int DMEM_DEPTH = 256;
	localparam int REG_COUNT  = 16;
	localparam int CNT_NUM    = 11;
	localparam int PC_W       = $clog2(IMEM_DEPTH);
	localparam int DA_W       = $clog2(DMEM_DEPTH);
	localparam int RIX_W      = $clog2(REG_COUNT);

	localparam logic [15:0] CYCLE_LIMIT_RST = 16'd45000;
	localparam logic [4:0]  NO_DEST         = 5'h1F;

	// Request codes.
	localparam logic [2:0] REQ_WR_INSTR = 3'd0;
	localparam logic [2:0] REQ_WR_DATA  = 3'd1;
	localparam logic [2:0] REQ_WR_REG   = 3'd2;
	localparam logic [2:0] REQ_TICK     = 3'd3;
	localparam logic [2:0] REQ_RD_DATA  = 3'd4;
	localparam logic [2:0] REQ_RD_REG   = 3'd5;
	localparam logic [2:0] REQ_RD_CNT   = 3'd6;

	// Instruction opcodes.
	localparam logic [3:0] OPC_ADD  = 4'd0;
	localparam logic [3:0] OPC_SUB  = 4'd1;
	localparam logic [3:0] OPC_MUL  = 4'd2;
	localparam logic [3:0] OPC_INC  = 4'd3;
	localparam logic [3:0] OPC_AND  = 4'd4;
	localparam logic [3:0] OPC_OR   = 4'd5;
	localparam logic [3:0] OPC_XOR  = 4'd6;
	localparam logic [3:0] OPC_NOT  = 4'd7;
	localparam logic [3:0] OPC_SHL  = 4'd8;
	localparam logic [3:0] OPC_SHR  = 4'd9;
	localparam logic [3:0] OPC_LI   = 4'd10;
	localparam logic [3:0] OPC_LD   = 4'd11;
	localparam logic [3:0] OPC_ST   = 4'd12;
	localparam logic [3:0] OPC_JMP  = 4'd13;
	localparam logic [3:0] OPC_BEQZ = 4'd14;
	localparam logic [3:0] OPC_HALT = 4'd15;

	// Statistics counter indexes.
	localparam logic [3:0] CNT_TOTAL  = 4'd0;
	localparam logic [3:0] CNT_ARITH  = 4'd1;
	localparam logic [3:0] CNT_LOGIC  = 4'd2;
	localparam logic [3:0] CNT_SHIFT  = 4'd3;
	localparam logic [3:0] CNT_MEM    = 4'd4;
	localparam logic [3:0] CNT_LI     = 4'd5;
	localparam logic [3:0] CNT_CTRL   = 4'd6;
	localparam logic [3:0] CNT_HALT   = 4'd7;
	localparam logic [3:0] CNT_CYCLES = 4'd8;
	localparam logic [3:0] CNT_STALLS = 4'd9;
	localparam logic [3:0] CNT_DSTALL = 4'd10;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  addr;
		logic [15:0] wdata;
	} req_t;

	typedef struct packed {
		logic [15:0] rdata;
		logic        halted;
	} rsp_t;

	typedef struct packed {
		logic [7:0] res;
		logic [3:0] cls;
		logic       br_take;
	} alu_out_t;

	// Target of a relative jump, wrapping over the instruction store.
	function automatic logic [PC_W-1:0] pc_rel(input logic [PC_W-1:0] pc,
			input logic [7:0] off);
		logic [31:0] sum;
		sum = 32'(pc) + 32'(signed'(off));
		return sum[PC_W-1:0];
	endfunction

endpackage

// File: rtl/core/fsp8_ram.sv
// ----------------------------------------------------------------------------
// fsp8_ram: generic single-port RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module fsp8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/core/fsp8_alu.sv
// ----------------------------------------------------------------------------
// fsp8_alu: execute stage datapath
// Computes the result of one instruction, its statistics class and whether
// a branch is taken.
// ----------------------------------------------------------------------------
module fsp8_alu import fsp8_pkg::*; (
	input  logic [3:0] opcode,
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  logic [7:0] imm,
	output alu_out_t   o
);

	logic [3:0] amt;
	logic [3:0] ramt;
	logic [7:0] sum4;

	function automatic logic [7:0] shl8(input logic [7:0] v, input logic [3:0] n);
		return (n >= 4'd8) ? 8'd0 : 8'(v << n[2:0]);
	endfunction

	function automatic logic [7:0] sra8(input logic [7:0] v, input logic [3:0] n);
		return 8'($signed(v) >>> n);
	endfunction

	assign amt  = imm[3:0];
	assign ramt = 4'(5'd16 - {1'b0, amt});
	assign sum4 = a + {{4{imm[3]}}, imm[3:0]};

	always_comb begin
		o = '0;
		unique case (opcode)
			OPC_ADD:  begin o.res = a + b;          o.cls = CNT_ARITH; end
			OPC_SUB:  begin o.res = a - b;          o.cls = CNT_ARITH; end
			OPC_MUL:  begin o.res = 8'(a * b);      o.cls = CNT_ARITH; end
			OPC_INC:  begin o.res = a + 8'd1;       o.cls = CNT_ARITH; end
			OPC_AND:  begin o.res = a & b;          o.cls = CNT_LOGIC; end
			OPC_OR:   begin o.res = a | b;          o.cls = CNT_LOGIC; end
			OPC_XOR:  begin o.res = a ^ b;          o.cls = CNT_LOGIC; end
			OPC_NOT:  begin o.res = ~a;             o.cls = CNT_LOGIC; end
			OPC_SHL:  begin
				o.res = amt[3] ? sra8(a, ramt) : shl8(a, {1'b0, amt[2:0]});
				o.cls = CNT_SHIFT;
			end
			OPC_SHR:  begin
				o.res = amt[3] ? shl8(a, ramt) : sra8(a, {1'b0, amt[2:0]});
				o.cls = CNT_SHIFT;
			end
			OPC_LI:   begin o.res = imm;            o.cls = CNT_LI;    end
			OPC_LD,
			OPC_ST:   begin o.res = sum4;           o.cls = CNT_MEM;   end
			OPC_JMP:  begin o.res = imm; o.br_take = 1'b1; o.cls = CNT_CTRL; end
			OPC_BEQZ: begin
				o.br_take = (a == 8'd0);
				o.res     = o.br_take ? imm : 8'd0;
				o.cls     = CNT_CTRL;
			end
			default:  o.cls = CNT_HALT;
		endcase
	end

endmodule

// File: rtl/core/five_stage_8bit_pipeline_cpu_top.sv
// ----------------------------------------------------------------------------
// five_stage_8bit_pipeline_cpu_top: five-stage 8-bit processor
// Request/response wrapper around an in-order pipeline with instruction and
// data stores in single-port RAMs.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless the response side
// stalls and returns exactly one response for each, in order, through the
// request stage, where a data read waits for the registered RAM read, and
// the output register. A tick request advances the processor by one step:
// write back, memory, execute, decode and fetch all happen in the same
// cycle, so ticks may arrive back to back. The instruction word and the
// loaded data byte leave their RAMs in the cycle after the tick that reads
// them, taken straight from the RAM output if the next tick follows at once
// and kept in holding registers otherwise. The stores start with undefined
// contents and need no clearing pass: software must write an entry before
// the program reads it; the block does not enforce this. Registers, busy
// counters and statistics counters reset to zero. The response carries the
// read value (zero for writes and ticks) and the halted flag, set once the
// budget runs down (halt instruction or limit); further ticks are ignored.
// Writing cfg_data loads the cycle limit and restarts the budget.
module five_stage_8bit_pipeline_cpu_top import fsp8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// Configuration and budget.
	logic [15:0] budget_q;
	logic        halt_q;

	// Processor state.
	logic [2:0]      fill_q;
	logic [PC_W-1:0] pc_q;
	logic [15:0]     fw_q;
	logic            fw_pend_q;
	logic            v1_q;
	logic [3:0]      op_s2, op_s3, op_s4;
	logic [4:0]      dest_s2, dest_s3, dest_s4;
	logic [7:0]      imm_s2;
	logic            v_s2, v_s3, v_s4;
	logic [7:0]      res_s3, res_s4;
	logic [7:0]      opa_q, opb_q, opc_q, rlmd_q;
	logic            rlmd_pend_q;
	logic [7:0]      regs_q [REG_COUNT];
	logic [2:0]      busy_q [REG_COUNT];
	logic [15:0]     cnt_q [CNT_NUM];

	// Response path.
	logic        s1_valid_q, s1_dm_q, s1_halt_q;
	logic [15:0] s1_rd_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// RAM ports.
	logic            im_en, im_we;
	logic [PC_W-1:0] im_addr;
	logic [15:0]     im_rdata;
	logic            dm_en, dm_we;
	logic [DA_W-1:0] dm_addr;
	logic [7:0]      dm_wdata, dm_rdata;

	logic     accept, tick_go, move;
	logic     mem_ld, mem_st, fetch_go;
	logic [15:0] fw_eff;
	logic [7:0]  rlmd_eff;
	alu_out_t alu_o;
	logic [15:0] direct_rd;

	// Next-state values of one tick.
	logic [7:0]      n_regs [REG_COUNT];
	logic [2:0]      n_busy [REG_COUNT];
	logic [15:0]     n_cnt [CNT_NUM];
	logic [PC_W-1:0] n_pc, fetch_pc;
	logic [15:0]     n_budget;
	logic            n_v0, n_v1, stall;
	logic [7:0]      n_opa, n_opb, n_opc, n_res3;
	logic [3:0]      d_op;
	logic [4:0]      d_dest;
	logic [7:0]      d_imm;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && req_ready;
	assign tick_go   = accept && (req.op == REQ_TICK) && !halt_q;
	assign move      = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || move;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A word read in the previous cycle is still on the RAM output.
	assign fw_eff   = fw_pend_q ? im_rdata : fw_q;
	assign rlmd_eff = rlmd_pend_q ? dm_rdata : rlmd_q;

	// The memory stage only acts while the budget allows it.
	assign mem_ld = (fill_q >= 3'd3) && v_s3 && (budget_q >= 16'd3) && (op_s3 == OPC_LD);
	assign mem_st = (fill_q >= 3'd3) && v_s3 && (budget_q >= 16'd3) && (op_s3 == OPC_ST);

	fsp8_alu u_alu (
		.opcode (op_s2),
		.a      (opa_q),
		.b      (opb_q),
		.imm    (imm_s2),
		.o      (alu_o)
	);

	// One tick of the pipeline, stages evaluated from write back to fetch so
	// that decode sees this cycle's write back and fetch sees a redirect.
	always_comb begin
		logic [15:0] w;
		logic [3:0]  fd, fs, ft, wd;
		n_regs   = regs_q;
		n_busy   = busy_q;
		n_cnt    = cnt_q;
		n_pc     = pc_q;
		n_budget = budget_q;
		n_v0     = 1'b1;
		n_v1     = v1_q;
		stall    = 1'b0;
		n_opa    = opa_q;
		n_opb    = opb_q;
		n_opc    = opc_q;
		n_res3   = 8'd0;
		d_op     = 4'd0;
		d_dest   = 5'd0;
		d_imm    = 8'd0;
		fetch_go = 1'b0;
		fetch_pc = pc_q;
		w        = fw_eff;
		fd       = w[11:8];
		fs       = w[7:4];
		ft       = w[3:0];
		wd       = dest_s4[3:0];

		// Write back.
		if (fill_q >= 3'd4 && v_s4 && budget_q >= 16'd2) begin
			if (op_s4 < OPC_LD) begin
				n_regs[wd] = res_s4;
				n_busy[wd] = n_busy[wd] - 3'd1;
			end else if (op_s4 == OPC_LD) begin
				n_regs[wd] = rlmd_eff;
				n_busy[wd] = n_busy[wd] - 3'd1;
			end
		end

		// Execute.
		if (fill_q >= 3'd2 && v_s2 && budget_q >= 16'd4) begin
			n_res3 = alu_o.res;
			n_cnt[alu_o.cls] = n_cnt[alu_o.cls] + 16'd1;
			n_cnt[CNT_TOTAL] = n_cnt[CNT_TOTAL] + 16'd1;
			if (op_s2 == OPC_ST) begin
				n_opc = opb_q;
			end
			if (op_s2 == OPC_JMP || op_s2 == OPC_BEQZ) begin
				n_v0 = 1'b0;
			end
			if (alu_o.br_take) begin
				n_pc = pc_rel(pc_q, imm_s2);
			end
		end

		// Decode, with a read-after-write interlock on the busy counters.
		if (fill_q >= 3'd1 && v1_q && budget_q > 16'd5) begin
			d_op = w[15:12];
			unique case (w[15:12])
				OPC_ADD, OPC_SUB, OPC_MUL, OPC_AND, OPC_OR, OPC_XOR: begin
					d_dest = {1'b0, fd};
					if (n_busy[fs] == 3'd0 && n_busy[ft] == 3'd0) begin
						n_opa = n_regs[fs];
						n_opb = n_regs[ft];
						n_busy[fd] = n_busy[fd] + 3'd1;
					end else begin
						stall = 1'b1;
					end
				end
				OPC_INC: begin
					d_dest = {1'b0, fd};
					if (n_busy[fd] == 3'd0) begin
						n_opa = n_regs[fd];
						n_busy[fd] = n_busy[fd] + 3'd1;
					end else begin
						stall = 1'b1;
					end
				end
				OPC_NOT, OPC_SHL, OPC_SHR, OPC_LD: begin
					d_dest = {1'b0, fd};
					if (n_busy[fs] == 3'd0) begin
						n_opa = n_regs[fs];
						d_imm = {4'd0, ft};
						n_busy[fd] = n_busy[fd] + 3'd1;
					end else begin
						stall = 1'b1;
					end
				end
				OPC_LI: begin
					d_dest = {1'b0, fd};
					d_imm  = {fs, ft};
					n_busy[fd] = n_busy[fd] + 3'd1;
				end
				OPC_ST: begin
					d_dest = NO_DEST;
					if (n_busy[fd] == 3'd0 && n_busy[fs] == 3'd0) begin
						n_opb = n_regs[fd];
						n_opa = n_regs[fs];
						d_imm = {4'd0, ft};
					end else begin
						stall = 1'b1;
					end
				end
				OPC_JMP: begin
					d_imm  = {fd, fs};
					d_dest = NO_DEST;
					n_v0   = 1'b0;
				end
				OPC_BEQZ: begin
					if (n_busy[fd] == 3'd0) begin
						d_imm  = {fs, ft};
						n_opa  = n_regs[fd];
						d_dest = NO_DEST;
						n_v0   = 1'b0;
					end else begin
						stall = 1'b1;
					end
				end
				default: n_budget = 16'd5;
			endcase
			if (stall) begin
				n_v0 = 1'b0;
				n_v1 = 1'b0;
			end
		end

		// Fetch, or count the bubble.
		if (n_v0 && n_budget > 16'd5) begin
			fetch_go = 1'b1;
			fetch_pc = n_pc;
			n_pc     = n_pc + PC_W'(1);
		end else begin
			if (stall) begin
				n_v0 = 1'b1;
				n_cnt[CNT_DSTALL] = n_cnt[CNT_DSTALL] + 16'd1;
			end
			if (n_budget > 16'd5) begin
				n_cnt[CNT_STALLS] = n_cnt[CNT_STALLS] + 16'd1;
			end
		end
		n_cnt[CNT_CYCLES] = n_cnt[CNT_CYCLES] + 16'd1;
		n_budget = n_budget - 16'd1;
	end

	// Instruction store port: fetch on a tick, writes from requests.
	always_comb begin
		im_en   = 1'b0;
		im_we   = 1'b0;
		im_addr = fetch_pc;
		if (tick_go) begin
			im_en = fetch_go;
		end else if (accept && req.op == REQ_WR_INSTR && 32'(req.addr) < IMEM_DEPTH) begin
			im_en   = 1'b1;
			im_we   = 1'b1;
			im_addr = PC_W'(req.addr);
		end
	end

	// Data store port: memory stage on a tick, reads and writes from requests.
	always_comb begin
		dm_en    = 1'b0;
		dm_we    = 1'b0;
		dm_addr  = req.addr;
		dm_wdata = req.wdata[7:0];
		if (tick_go) begin
			dm_en    = mem_ld || mem_st;
			dm_we    = mem_st;
			dm_addr  = res_s3;
			dm_wdata = opc_q;
		end else if (accept && (req.op == REQ_WR_DATA || req.op == REQ_RD_DATA)) begin
			dm_en = 1'b1;
			dm_we = (req.op == REQ_WR_DATA);
		end
	end

	fsp8_ram #(.WIDTH(16), .DEPTH(IMEM_DEPTH)) u_imem (
		.clk   (clk),
		.en    (im_en),
		.we    (im_we),
		.addr  (im_addr),
		.wdata (req.wdata),
		.rdata (im_rdata)
	);

	fsp8_ram #(.WIDTH(8), .DEPTH(DMEM_DEPTH)) u_dmem (
		.clk   (clk),
		.en    (dm_en),
		.we    (dm_we),
		.addr  (dm_addr),
		.wdata (dm_wdata),
		.rdata (dm_rdata)
	);

	// Read value of requests that do not wait for the data RAM.
	always_comb begin
		direct_rd = 16'd0;
		unique case (req.op)
			REQ_RD_REG: begin
				if (req.addr < 8'(REG_COUNT)) begin
					direct_rd = {8'd0, regs_q[req.addr[RIX_W-1:0]]};
				end
			end
			REQ_RD_CNT: begin
				if (req.addr < 8'(CNT_NUM)) begin
					direct_rd = cnt_q[req.addr[3:0]];
				end
			end
			default: direct_rd = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= CYCLE_LIMIT_RST;
			halt_q      <= 1'b0;
			fill_q      <= 3'd0;
			pc_q        <= '0;
			fw_q        <= 16'd0;
			fw_pend_q   <= 1'b0;
			v1_q        <= 1'b1;
			op_s2       <= 4'd0;
			op_s3       <= 4'd0;
			op_s4       <= 4'd0;
			dest_s2     <= 5'd0;
			dest_s3     <= 5'd0;
			dest_s4     <= 5'd0;
			imm_s2      <= 8'd0;
			v_s2        <= 1'b1;
			v_s3        <= 1'b1;
			v_s4        <= 1'b1;
			res_s3      <= 8'd0;
			res_s4      <= 8'd0;
			opa_q       <= 8'd0;
			opb_q       <= 8'd0;
			opc_q       <= 8'd0;
			rlmd_q      <= 8'd0;
			rlmd_pend_q <= 1'b0;
			regs_q      <= '{default: 8'd0};
			busy_q      <= '{default: 3'd0};
			cnt_q       <= '{default: 16'd0};
		end else begin
			fw_q        <= fw_eff;
			fw_pend_q   <= tick_go && fetch_go;
			rlmd_q      <= rlmd_eff;
			rlmd_pend_q <= tick_go && mem_ld;
			if (tick_go) begin
				budget_q <= n_budget;
				halt_q   <= (n_budget < 16'd2);
				fill_q   <= (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
				pc_q     <= n_pc;
				v1_q     <= n_v0;
				op_s2    <= d_op;
				dest_s2  <= d_dest;
				imm_s2   <= d_imm;
				v_s2     <= n_v1;
				op_s3    <= op_s2;
				dest_s3  <= dest_s2;
				v_s3     <= v_s2;
				res_s3   <= n_res3;
				op_s4    <= op_s3;
				dest_s4  <= dest_s3;
				v_s4     <= v_s3;
				res_s4   <= res_s3;
				opa_q    <= n_opa;
				opb_q    <= n_opb;
				opc_q    <= n_opc;
				regs_q   <= n_regs;
				busy_q   <= n_busy;
				cnt_q    <= n_cnt;
			end else if (accept && req.op == REQ_WR_REG && req.addr < 8'(REG_COUNT)) begin
				regs_q[req.addr[RIX_W-1:0]] <= req.wdata[7:0];
			end
			if (cfg_valid && cfg_ready) begin
				budget_q <= cfg_data;
				halt_q   <= (cfg_data < 16'd2);
			end
		end
	end

	// Response path: a request stage that waits for the data RAM read, then
	// the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= accept || (s1_valid_q && !move);
			rsp_valid_q <= move || (rsp_valid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_rd_q   <= direct_rd;
			s1_dm_q   <= (req.op == REQ_RD_DATA);
			s1_halt_q <= tick_go ? (n_budget < 16'd2) : halt_q;
		end
		if (move) begin
			rsp_q.rdata  <= s1_dm_q ? {8'd0, dm_rdata} : s1_rd_q;
			rsp_q.halted <= s1_halt_q;
		end
	end

`ifndef SYNTHESIS
	a_ready_only_blocked_by_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> s1_valid_q)
		else $error("request stage blocked without a pending request");
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd4)
		else $error("fill level beyond pipeline depth");
	a_fetch_pend_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go && fetch_go |=> fw_pend_q)
		else $error("fetched word not marked pending");
	a_budget_halt: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q == (budget_q < 16'd2))
		else $error("halt flag out of step with budget");
`endif

endmodule
